@@ rtl/core/rfid_page_crc_check_defines.svh @@
// ----------------------------------------------------------------------------
// Page CRC check assertion macros
// Shared assertion helpers for the page CRC check pipeline.
// ----------------------------------------------------------------------------
`ifndef RFID_PAGE_CRC_CHECK_DEFINES_SVH
`define RFID_PAGE_CRC_CHECK_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RPCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RPCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/rpcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Page CRC check package
// Shared constants, pipeline item type and the CRC-8 byte function.
// ----------------------------------------------------------------------------
package rpcc_pkg;

  localparam logic [7:0]  CrcPoly    = 8'h1D;
  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam logic [31:0] SelectBits = 32'hC000_0000;

  typedef enum logic [1:0] {
    StReject   = 2'd0,
    StMatch    = 2'd1,
    StShift    = 2'd2,
    StStandard = 2'd3
  } status_e;

  typedef struct packed {
    logic        mode;
    logic        ok;
    logic [7:0]  rcrc;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [7:0]  c1;
    logic [7:0]  c2;
  } item_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/rpcc_prep.sv @@
// ----------------------------------------------------------------------------
// Page CRC check input stage
// Holds the mode register and registers the frame with both candidate words.
// ----------------------------------------------------------------------------
module rpcc_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  output logic                 valid_o,
  output rpcc_pkg::item_t      item_o,
  input  logic                 ready_i
);

  logic            mode_q;
  logic            valid_q;
  rpcc_pkg::item_t item_d;
  rpcc_pkg::item_t item_q;
  logic [31:0]     raw;
  logic [31:0]     sel_bits;

  assign raw      = s_axis_tdata[39:8];
  assign sel_bits = s_axis_tuser[0] ? rpcc_pkg::SelectBits : 32'h0;

  always_comb begin
    item_d      = item_q;
    item_d.mode = mode_q;
    item_d.ok   = s_axis_tuser[1];
    item_d.rcrc = s_axis_tdata[7:0];
    item_d.d1   = raw | sel_bits;
    item_d.d2   = {raw[30:0], 1'b0} | sel_bits;
    item_d.w1   = raw | sel_bits;
    item_d.w2   = {raw[30:0], 1'b0} | sel_bits;
    item_d.c1   = rpcc_pkg::CrcInit;
    item_d.c2   = rpcc_pkg::CrcInit;
  end

  assign s_axis_tready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/rpcc_crc_stage.sv @@
// ----------------------------------------------------------------------------
// Page CRC check CRC stage
// Advances both CRC lanes over the next two data bytes and registers them.
// ----------------------------------------------------------------------------
`include "rfid_page_crc_check_defines.svh"

module rpcc_crc_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rpcc_pkg::item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output rpcc_pkg::item_t item_o,
  input  logic            ready_i
);

  logic            valid_q;
  rpcc_pkg::item_t item_d;
  rpcc_pkg::item_t item_q;

  always_comb begin
    item_d    = item_i;
    item_d.c1 = rpcc_pkg::crc8_byte(rpcc_pkg::crc8_byte(item_i.c1, item_i.w1[31:24]),
                                    item_i.w1[23:16]);
    item_d.c2 = rpcc_pkg::crc8_byte(rpcc_pkg::crc8_byte(item_i.c2, item_i.w2[31:24]),
                                    item_i.w2[23:16]);
    item_d.w1 = {item_i.w1[15:0], 16'h0};
    item_d.w2 = {item_i.w2[15:0], 16'h0};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  // A stalled stage must keep its item.
  `RPCC_ASSERT(a_stage_hold, valid_q && !ready_i |=> valid_q && $stable(item_q), "stage lost a stalled item")

endmodule

@@ rtl/core/rpcc_decide.sv @@
// ----------------------------------------------------------------------------
// Page CRC check decision stage
// Compares the CRC lanes, picks the page word and status, and drives the output.
// ----------------------------------------------------------------------------
`include "rfid_page_crc_check_defines.svh"

module rpcc_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rpcc_pkg::item_t item_i,
  output logic            ready_o,
  output logic            out_valid_o,
  output logic [31:0]     out_data_o,
  output logic [2:0]      out_user_o,
  input  logic            out_ready_i
);

  logic              valid_q;
  logic              page_valid_d;
  logic              page_valid_q;
  logic [31:0]       data_d;
  logic [31:0]       data_q;
  rpcc_pkg::status_e status_d;
  rpcc_pkg::status_e status_q;
  logic [7:0]        rcrc_shift;

  assign rcrc_shift = {item_i.rcrc[6:0], 1'b0};

  always_comb begin
    page_valid_d = 1'b0;
    data_d       = 32'h0;
    status_d     = rpcc_pkg::StReject;
    if (item_i.ok) begin
      if (!item_i.mode) begin
        page_valid_d = 1'b1;
        data_d       = ~{item_i.d1[23:0], item_i.rcrc};
        status_d     = rpcc_pkg::StStandard;
      end else if (item_i.c1 == item_i.rcrc) begin
        page_valid_d = 1'b1;
        data_d       = item_i.d1;
        status_d     = rpcc_pkg::StMatch;
      end else if (item_i.c2[7:1] == rcrc_shift[7:1]) begin
        page_valid_d = 1'b1;
        data_d       = item_i.d2;
        status_d     = rpcc_pkg::StShift;
      end
    end
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      page_valid_q <= page_valid_d;
      data_q       <= data_d;
      status_q     <= status_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = {status_q, page_valid_q};

  // A rejected frame carries no page word.
  `RPCC_ASSERT(a_reject_zero, valid_q && status_q == rpcc_pkg::StReject |-> data_q == 32'h0 && !page_valid_q, "rejected result has data")
  // The valid flag and the status agree.
  `RPCC_ASSERT(a_valid_status, valid_q |-> page_valid_q == (status_q != rpcc_pkg::StReject), "page valid and status disagree")

endmodule

@@ rtl/core/rfid_page_crc_check.sv @@
// ----------------------------------------------------------------------------
// RFID page CRC check
// Checks received tag response frames against CRC-8 and extracts the page word.
// ----------------------------------------------------------------------------
// The slave stream takes one 40-bit frame per transfer with its select and
// receive-complete flags in tuser. The master stream returns one result per
// frame: the page word in tdata, and the valid flag and check status in tuser.
// The user is to write the mode register through cfg_we_i and cfg_wdata_i
// only while no frame is in flight; the block does not enforce this. Each
// frame uses the mode seen as it enters. The pipeline has four register
// stages: input capture, CRC over the upper two bytes, CRC over the lower two
// bytes, and the decision and output register. One frame is taken in every
// cycle unless the receiver stalls.
// When the receiver stalls, the stages fill up in order and the slave side
// drops tready only once every stage holds a frame; nothing is lost or
// repeated. Reset clears the mode register to standard mode and empties the
// pipeline.
// ----------------------------------------------------------------------------
`include "rfid_page_crc_check_defines.svh"

module rfid_page_crc_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // frame_bits
  input  logic [1:0]  s_axis_tuser,  // is_select, receive_ok
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // page_data
  output logic [2:0]  m_axis_tuser   // page_valid, check_status
);

  logic            prep_valid;
  logic            hi_valid;
  logic            lo_valid;
  logic            hi_ready;
  logic            lo_ready;
  logic            dec_ready;
  rpcc_pkg::item_t prep_item;
  rpcc_pkg::item_t hi_item;
  rpcc_pkg::item_t lo_item;

  rpcc_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .valid_o      (prep_valid),
    .item_o       (prep_item),
    .ready_i      (hi_ready)
  );

  rpcc_crc_stage u_crc_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(prep_valid),
    .item_i (prep_item),
    .ready_o(hi_ready),
    .valid_o(hi_valid),
    .item_o (hi_item),
    .ready_i(lo_ready)
  );

  rpcc_crc_stage u_crc_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(hi_valid),
    .item_i (hi_item),
    .ready_o(lo_ready),
    .valid_o(lo_valid),
    .item_o (lo_item),
    .ready_i(dec_ready)
  );

  rpcc_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (lo_valid),
    .item_i     (lo_item),
    .ready_o    (dec_ready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_ready_i(m_axis_tready)
  );

  // The input side only stalls when the whole pipeline is full and blocked.
  `RPCC_ASSERT_ALWAYS(a_stall_full, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && prep_valid && hi_valid && lo_valid, "input stalled with room in the pipeline")

endmodule

@@ dv/rfid_page_crc_check_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RFID page CRC check testbench
// Drives response frames into the checker in standard and advanced mode.
// Every returned page word, valid flag and status is compared with a local
// CRC-8 predictor, under several sender and receiver flow-control mixes.
// ----------------------------------------------------------------------------
module rfid_page_crc_check_tb;

  typedef struct {
    logic              page_valid;
    logic [31:0]       page_data;
    rpcc_pkg::status_e check_status;
  } page_result_t;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  logic         adv_mode = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  page_result_t pending_pages[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  frames_sent = 0;
  int unsigned  status_seen[4] = '{0, 0, 0, 0};

  rfid_page_crc_check DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] page_crc8(logic [31:0] word);
    logic [7:0] crc;
    crc = rpcc_pkg::CrcInit;
    for (int b = 3; b >= 0; b--) begin
      crc ^= word[8*b +: 8];
      for (int k = 0; k < 8; k++) begin
        crc = crc[7] ? ({crc[6:0], 1'b0} ^ rpcc_pkg::CrcPoly) : {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] sel_word(logic [31:0] raw, logic sel);
    return sel ? (raw | rpcc_pkg::SelectBits) : raw;
  endfunction

  function automatic page_result_t predict_page(logic [39:0] frame, logic sel, logic ok,
                                                logic mode);
    page_result_t r;
    logic [31:0]  d1;
    logic [31:0]  d2;
    logic [7:0]   r2;
    logic [7:0]   c2;
    r = '{1'b0, 32'h0, rpcc_pkg::StReject};
    if (ok && !mode) begin
      r = '{1'b1, ~frame[31:0], rpcc_pkg::StStandard};
    end else if (ok) begin
      d1 = sel_word(frame[39:8], sel);
      d2 = sel_word({frame[38:8], 1'b0}, sel);
      r2 = {frame[6:0], 1'b0};
      c2 = page_crc8(d2);
      if (page_crc8(d1) == frame[7:0]) begin
        r = '{1'b1, d1, rpcc_pkg::StMatch};
      end else if (c2 == r2 || c2 == (r2 | 8'h01)) begin
        r = '{1'b1, d2, rpcc_pkg::StShift};
      end
    end
    return r;
  endfunction

  function automatic logic [39:0] good_frame(logic [31:0] raw, logic sel);
    return {raw, page_crc8(sel_word(raw, sel))};
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               pending_pages.size());
      $display("rfid_page_crc_check_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_pages
    page_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_seen[m_axis_tuser[2:1]]++;
      if (pending_pages.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result transfer: data %h user %b", m_axis_tdata, m_axis_tuser);
        end
      end else begin
        want = pending_pages.pop_front();
        if (m_axis_tuser[0] !== want.page_valid || m_axis_tdata !== want.page_data ||
            m_axis_tuser[2:1] !== want.check_status) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch (valid/data/status): expected %b/%h/%0d, got %b/%h/%0d",
                     want.page_valid, want.page_data, want.check_status,
                     m_axis_tuser[0], m_axis_tdata, m_axis_tuser[2:1]);
          end
        end
      end
    end
  end

  task automatic send_frame(logic [39:0] frame, logic sel, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= frame;
    s_axis_tuser  <= {ok, sel};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_pages.push_back(predict_page(frame, sel, ok, adv_mode));
    frames_sent++;
  endtask

  task automatic write_mode(logic mode);
    s_axis_tvalid <= 1'b0;
    while (pending_pages.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    adv_mode = mode;
  endtask

  task automatic send_random_frame();
    logic [31:0] raw;
    logic [39:0] frame;
    logic [7:0]  c2;
    logic        sel;
    int unsigned kind;
    raw   = $urandom;
    sel   = 1'($urandom);
    frame = {8'($urandom), 32'($urandom)};
    kind  = $urandom_range(99);
    if (!adv_mode) begin
      send_frame(frame, sel, $urandom_range(9) != 0);
    end else if (kind < 40) begin
      send_frame(good_frame(raw, sel), sel, 1'b1);
    end else if (kind < 70) begin
      c2 = page_crc8(sel_word({raw[30:0], 1'b0}, sel));
      send_frame({raw, 1'($urandom), c2[7:1]}, sel, 1'b1);
    end else if (kind < 85) begin
      send_frame(frame, sel, 1'b1);
    end else if (kind < 92) begin
      send_frame(good_frame(raw, sel) ^ (40'h1 << $urandom_range(39)), sel, 1'b1);
    end else begin
      send_frame(good_frame(raw, sel), sel, 1'b0);
    end
  endtask

  task automatic test_standard_after_reset();
    send_frame(40'h00_0000_0000, 1'b0, 1'b1);
    send_frame(40'hFF_FFFF_FFFF, 1'b0, 1'b1);
    send_frame(40'hA5_5AC3_3C96, 1'b1, 1'b1);
    send_frame(40'hFF_0000_0000, 1'b1, 1'b1);
    send_frame(40'h12_3456_789A, 1'b0, 1'b0);
    write_mode(1'b0);
    send_frame(40'h00_FFFF_0000, 1'b1, 1'b1);
  endtask

  task automatic test_advanced_directed();
    logic [31:0] raw;
    logic [39:0] frame;
    logic [7:0]  c2;
    logic        sel;
    write_mode(1'b1);
    send_frame(good_frame(32'h0000_0000, 1'b0), 1'b0, 1'b1);
    send_frame(good_frame(32'hFFFF_FFFF, 1'b0), 1'b0, 1'b1);
    send_frame(good_frame(32'h1234_5678, 1'b1), 1'b1, 1'b1);
    send_frame(good_frame(32'h0000_0000, 1'b1), 1'b1, 1'b1);
    send_frame(good_frame(32'h0F0F_0F0F, 1'b0), 1'b1, 1'b1);
    send_frame(good_frame(32'hDEAD_BEEF, 1'b0), 1'b0, 1'b0);
    send_frame(good_frame(32'hCAFE_0001, 1'b0) ^ 40'h5A, 1'b0, 1'b1);
    send_frame(40'h00_0000_0000, 1'b0, 1'b1);
    send_frame(40'hFF_FFFF_FFFF, 1'b1, 1'b1);
    // Shifted retries: exact match, match with the low CRC bit set, and with data bit 31 set.
    for (int i = 0; i < 3; i++) begin
      do begin
        raw = $urandom;
        if (i == 2) raw[31] = 1'b1;
        sel   = (i == 1);
        c2    = page_crc8(sel_word({raw[30:0], 1'b0}, sel));
        frame = {raw, 1'($urandom), c2[7:1]};
      end while (c2[0] != (i == 1) || page_crc8(sel_word(raw, sel)) == frame[7:0]);
      send_frame(frame, sel, 1'b1);
    end
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_mode(1'b1);
    repeat (80) send_random_frame();
    write_mode(1'b0);
    repeat (30) send_random_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_standard_after_reset();
    test_advanced_directed();
    test_random_traffic(0, 0);
    test_random_traffic(83, 0);
    test_random_traffic(0, 83);
    test_random_traffic(38, 38);
    s_axis_tvalid <= 1'b0;
    while (pending_pages.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d frames in standard and advanced mode under four flow-control mixes.",
             frames_sent);
    $display("Results seen: %0d rejected, %0d CRC match, %0d shifted match, %0d unchecked.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("rfid_page_crc_check_tb: clean");
    end else begin
      $display("rfid_page_crc_check_tb: errors");
    end
    $finish;
  end

endmodule
